// ===== rtl/core/mlc_pkg.sv =====
package mlc_pkg;

   localparam int PROCESSES_DEF   = 4;
   localparam int COUNT_WIDTH_DEF = 16;

   // fixed field widths of the channel words
   localparam int PROC_W  = 2;
   localparam int VALUE_W = 16;

   localparam logic [1:0] CMD_LOCAL = 2'd0;
   localparam logic [1:0] CMD_SEND  = 2'd1;
   localparam logic [1:0] CMD_RECV  = 2'd2;

   typedef enum logic [1:0] {
      RD_REQ,
      RD_DIAG,
      RD_SEND,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       take;
      rd_sel_type rd_sel;
      logic       wr_bump;
      logic       wr_merge;
      logic       out_load;
      logic       send_next;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] req_command;
      logic       cmd_send;
      logic       entry_last;
      logic       out_taken;
      logic       send_last;
   } ctrl_status_type;

endpackage

// ===== rtl/core/mlc_req_if.sv =====
interface mlc_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       command;
   logic [mlc_pkg::PROC_W-1:0]       dest_process;
   logic [mlc_pkg::PROC_W-1:0]       entry_row;
   logic [mlc_pkg::PROC_W-1:0]       entry_col;
   logic [mlc_pkg::VALUE_W-1:0]      entry_value;
   logic                             entry_last;

   modport source (
      output valid, command, dest_process, entry_row, entry_col, entry_value, entry_last,
      input  ready
   );
   modport sink (
      input  valid, command, dest_process, entry_row, entry_col, entry_value, entry_last,
      output ready
   );
endinterface

// ===== rtl/core/mlc_rsp_if.sv =====
interface mlc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mlc_pkg::PROC_W-1:0]  destination;
   logic [mlc_pkg::PROC_W-1:0]  out_row;
   logic [mlc_pkg::PROC_W-1:0]  out_col;
   logic [mlc_pkg::VALUE_W-1:0] out_value;
   logic                        out_last;

   modport source (
      output valid, destination, out_row, out_col, out_value, out_last,
      input  ready
   );
   modport sink (
      input  valid, destination, out_row, out_col, out_value, out_last,
      output ready
   );
endinterface

// ===== rtl/core/mlc_ctrl.sv =====
module mlc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  mlc_pkg::ctrl_status_type status,
   output mlc_pkg::ctrl_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_BUMP_WR  = 3'd1;
   localparam logic [2:0] S_MERGE_WR = 3'd2;
   localparam logic [2:0] S_BUMP_RD  = 3'd3;
   localparam logic [2:0] S_SEND_RD  = 3'd4;
   localparam logic [2:0] S_LOAD     = 3'd5;
   localparam logic [2:0] S_WAIT     = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      cmd.rd_sel = mlc_pkg::RD_REQ;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take   = 1'b1;
            cmd.rd_sel = mlc_pkg::RD_REQ;
            if (status.req_valid) begin
               priority if (status.req_command == mlc_pkg::CMD_LOCAL) begin
                  state_in = S_BUMP_WR;
               end else if (status.req_command == mlc_pkg::CMD_SEND) begin
                  state_in = S_BUMP_WR;
               end else if (status.req_command == mlc_pkg::CMD_RECV) begin
                  state_in = S_MERGE_WR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_BUMP_WR: begin
            cmd.wr_bump = 1'b1;
            state_in    = status.cmd_send ? S_SEND_RD : S_IDLE;
         end
         S_MERGE_WR: begin
            cmd.wr_merge = 1'b1;
            state_in     = status.entry_last ? S_BUMP_RD : S_IDLE;
         end
         S_BUMP_RD: begin
            cmd.rd_sel = mlc_pkg::RD_DIAG;
            state_in   = S_BUMP_WR;
         end
         S_SEND_RD: begin
            cmd.rd_sel = mlc_pkg::RD_SEND;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            cmd.out_load = 1'b1;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            if (status.out_taken) begin
               if (status.send_last) begin
                  state_in = S_IDLE;
               end else begin
                  // fetch the next entry while the word leaves
                  cmd.send_next = 1'b1;
                  cmd.rd_sel    = mlc_pkg::RD_NEXT;
                  state_in      = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/mlc_datapath.sv =====
module mlc_datapath #(
   parameter int PROCESSES   = mlc_pkg::PROCESSES_DEF,
   parameter int COUNT_WIDTH = mlc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [mlc_pkg::PROC_W-1:0]    csr_write_data,
   mlc_req_if.sink                       req_bus,
   mlc_rsp_if.source                     rsp_bus,
   input  mlc_pkg::ctrl_cmd_type         cmd,
   output mlc_pkg::ctrl_status_type      status
);

   localparam int CELLS   = PROCESSES * PROCESSES;
   localparam int AW      = $clog2(CELLS);
   localparam int RW      = $clog2(PROCESSES);
   localparam int CMP_W   = (COUNT_WIDTH > mlc_pkg::VALUE_W) ? COUNT_WIDTH : mlc_pkg::VALUE_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
   localparam logic [RW-1:0] LAST_COL  = RW'(PROCESSES - 1);

   // configuration
   logic [mlc_pkg::PROC_W-1:0] proc_index_ff;
   logic [AW-1:0]              diag_addr;
   logic                       own_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_index_ff <= '0;
      end else if (csr_write_enable) begin
         proc_index_ff <= csr_write_data;
      end
   end

   assign diag_addr = AW'(int'(proc_index_ff) * (PROCESSES + 1));
   assign own_ok    = int'(proc_index_ff) < PROCESSES;

   // input word capture
   logic                        accept;
   logic                        req_in_range;
   logic [AW-1:0]               req_addr;
   logic [1:0]                  cmd_ff;
   logic [mlc_pkg::PROC_W-1:0]  dest_ff;
   logic [AW-1:0]               entry_addr_ff;
   logic                        in_range_ff;
   logic [mlc_pkg::VALUE_W-1:0] value_ff;
   logic                        last_ff;

   // no word is taken while reset is held
   assign req_bus.ready = cmd.take & ~reset;
   assign accept        = req_bus.valid & req_bus.ready;
   assign req_in_range  = (int'(req_bus.entry_row) < PROCESSES) &&
                          (int'(req_bus.entry_col) < PROCESSES);
   assign req_addr      = (req_bus.command == mlc_pkg::CMD_RECV && req_in_range) ?
                          AW'(int'(req_bus.entry_row) * PROCESSES + int'(req_bus.entry_col)) :
                          diag_addr;

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_bus.command;
         dest_ff       <= req_bus.dest_process;
         entry_addr_ff <= req_addr;
         in_range_ff   <= req_in_range;
         value_ff      <= req_bus.entry_value;
         last_ff       <= req_bus.entry_last;
      end
   end

   // send position counters
   logic [AW-1:0] addr_ff, addr_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] col_ff, col_in;

   always_comb begin
      addr_in = addr_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (accept) begin
         addr_in = '0;
         row_in  = '0;
         col_in  = '0;
      end else if (cmd.send_next) begin
         addr_in = addr_ff + AW'(1);
         if (col_ff == LAST_COL) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         addr_ff <= addr_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   // counter store with per-entry valid bits, unwritten entries read as zero
   logic [COUNT_WIDTH-1:0] mem [CELLS];
   logic [CELLS-1:0]       valid_ff;
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   wr_en;
   logic [COUNT_WIDTH-1:0] cur;
   logic [CMP_W-1:0]       value_wide;
   logic [COUNT_WIDTH-1:0] value_clamped;
   logic [COUNT_WIDTH-1:0] merged;
   logic [COUNT_WIDTH-1:0] bumped;

   always_comb begin
      unique case (cmd.rd_sel)
         mlc_pkg::RD_REQ:  rd_addr = req_addr;
         mlc_pkg::RD_DIAG: rd_addr = diag_addr;
         mlc_pkg::RD_SEND: rd_addr = addr_ff;
         mlc_pkg::RD_NEXT: rd_addr = addr_ff + AW'(1);
      endcase
   end

   assign cur           = rd_valid_ff ? rd_data_ff : '0;
   assign value_wide    = CMP_W'(value_ff);
   assign value_clamped = (value_wide > CMP_W'(COUNT_MAX)) ? COUNT_MAX :
                          COUNT_WIDTH'(value_wide);
   assign merged        = (cur < value_clamped) ? value_clamped : cur;
   assign bumped        = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);

   assign wr_en   = (cmd.wr_bump & own_ok) | (cmd.wr_merge & in_range_ff);
   assign wr_addr = cmd.wr_merge ? entry_addr_ff : diag_addr;
   assign wr_data = cmd.wr_merge ? merged : bumped;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // result word register
   logic                        out_valid_ff, out_valid_in;
   logic [mlc_pkg::PROC_W-1:0]  out_dest_ff;
   logic [mlc_pkg::PROC_W-1:0]  out_row_ff;
   logic [mlc_pkg::PROC_W-1:0]  out_col_ff;
   logic [mlc_pkg::VALUE_W-1:0] out_value_ff;
   logic                        out_last_ff;
   logic                        out_taken;

   assign out_taken = out_valid_ff & rsp_bus.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (out_taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_dest_ff  <= dest_ff;
         out_row_ff   <= mlc_pkg::PROC_W'(row_ff);
         out_col_ff   <= mlc_pkg::PROC_W'(col_ff);
         out_value_ff <= mlc_pkg::VALUE_W'(cur);
         out_last_ff  <= (addr_ff == LAST_ADDR);
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.destination = out_dest_ff;
   assign rsp_bus.out_row     = out_row_ff;
   assign rsp_bus.out_col     = out_col_ff;
   assign rsp_bus.out_value   = out_value_ff;
   assign rsp_bus.out_last    = out_last_ff;

   // status back to the sequencer
   assign status.req_valid   = req_bus.valid;
   assign status.req_command = req_bus.command;
   assign status.cmd_send    = (cmd_ff == mlc_pkg::CMD_SEND);
   assign status.entry_last  = last_ff;
   assign status.out_taken   = out_taken;
   assign status.send_last   = (addr_ff == LAST_ADDR);

   // no new word is taken while a matrix entry is still pending
   a_no_take_while_out : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !cmd.take)
      else $error("input taken while result word pending");

   // store write and result load never coincide with taking a new word
   a_no_write_on_take : assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !(cmd.wr_bump || cmd.wr_merge || cmd.out_load))
      else $error("store write or load while idle");

   // a reset leaves every entry reading as zero
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("valid bits not cleared by reset");

   // a word taken mid-matrix is followed by a gap before the next one
   a_gap_after_take : assert property (@(posedge clock) disable iff (reset)
      (out_taken && !status.send_last) |=> !out_valid_ff)
      else $error("result word repeated");

endmodule

// ===== rtl/core/matrix_logical_clock.sv =====
// Matrix logical clock for one process among PROCESSES. Commands arrive one word at a time:
// a local event bumps the own diagonal counter, a received matrix entry is merged into the
// store (with the last mark it also bumps the own diagonal counter), and a send bumps the own
// diagonal counter, then emits every entry, each held until the result side takes it.
// The counter store has a registered read: every update of it is a read followed by a write,
// and each emitted entry is one registered read from the store. No new command is
// accepted until the current one finishes. Counters saturate at their maximum, are all zero
// after reset, and process_index may only be changed while the block is idle.
module matrix_logical_clock #(
   parameter int PROCESSES   = mlc_pkg::PROCESSES_DEF,
   parameter int COUNT_WIDTH = mlc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [mlc_pkg::PROC_W-1:0] csr_write_data,
   mlc_req_if.sink                    req_bus,
   mlc_rsp_if.source                  rsp_bus
);

   mlc_pkg::ctrl_cmd_type    cmd;
   mlc_pkg::ctrl_status_type status;

   mlc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   mlc_datapath #(
      .PROCESSES   (PROCESSES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
